// ===== rtl/core/wbps_pkg.sv =====
package wbps_pkg;

  // Field widths of the stream beats and config registers
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned PAT_REG_W = 64;
  localparam int unsigned CARE_W    = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = PAT_REG_W;

  // Stream payload widths (tdata padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 64;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO = 2'd0,
    CFG_PAT_HI = 2'd1,
    CFG_CARE   = 2'd2,
    CFG_LEN    = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [CARE_W-1:0] CARE_RST = '1;
  localparam logic [LEN_W-1:0]  LEN_RST  = 5'd1;

endpackage

// ===== rtl/core/wildcard_byte_pattern_search_core.sv =====
// Channel | Direction | Beat contents
// --------+-----------+-----------------------------------------------------------
// in_     | slave     | tdata: data_byte[7:0], byte_address[39:8]; tlast: last_byte
// out_    | master    | tdata: match_count[31:0], match_location[63:32]
// cfg_    | write     | cfg_we, cfg_index (register), cfg_data (up to 64 bits)
//
// One byte beat is accepted every cycle while in_tready is high. A beat is
// registered, then the window shift, the parallel compare and the counters update
// as it leaves the input stage; a tlast beat's result then loads the out_ register.
// The only stall source is a held result: a tlast beat waits in the input stage
// while out_ is full and not taken, and in_tready drops only then.
// rst_n (synchronous) empties both stages, clears the search state and restores
// the register defaults (care mask all ones, pattern length one).
module wildcard_byte_pattern_search_core #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // data_byte [7:0], byte_address [39:8]
  input  logic [wbps_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tlast,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // match_count [31:0], match_location [63:32]
  output logic [wbps_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import wbps_pkg::*;

  localparam int unsigned SEEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PATTERN);
  localparam logic [SEEN_W-1:0] MAX_SEEN = SEEN_W'(MAX_PATTERN);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [PAT_REG_W-1:0] pat_lo_r;
  logic [PAT_REG_W-1:0] pat_hi_r;
  logic [CARE_W-1:0]    care_r;
  logic [LEN_W-1:0]     len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= CARE_RST;
      len_r    <= LEN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PAT_LO: pat_lo_r <= cfg_data;
        CFG_PAT_HI: pat_hi_r <= cfg_data;
        CFG_CARE:   care_r   <= cfg_data[CARE_W-1:0];
        CFG_LEN:    len_r    <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: one registered beat
  // ---------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_last_r;
  logic              s1_go;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // A beat moves on unless it carries tlast and the result slot is blocked.
  assign s1_go     = s1_valid_r && !(s1_last_r && out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[BYTE_W-1:0];
      s1_addr_r <= in_tdata[BYTE_W +: ADDR_W];
      s1_last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Search state: byte window (entry 0 newest), fill count, match tally
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  win_r   [MAX_PATTERN];
  logic [BYTE_W-1:0]  win_nxt [MAX_PATTERN];
  logic [SEEN_W-1:0]  seen_r, seen_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ADDR_W-1:0]  start_r, start_nxt;

  logic [LEN_W-1:0]   len_eff;
  logic [2*PAT_REG_W-1:0] pat_all;
  logic               hit;

  assign len_eff = (len_r > MAX_LEN) ? MAX_LEN : len_r;
  assign pat_all = {pat_hi_r, pat_lo_r};

  // Shift in the new byte and compare every window slot against the pattern
  // byte that lines up with it; slot j holds pattern byte len-1-j.
  always_comb begin
    logic [LEN_W-1:0] k;
    logic             ok;
    ok = 1'b1;
    k  = '0;
    win_nxt[0] = s1_data_r;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
    for (int j = 0; j < MAX_PATTERN; j++) begin
      k = len_eff - LEN_W'(j) - LEN_W'(1);
      if ((LEN_W'(j) < len_eff) && care_r[k[3:0]] &&
          (win_nxt[j] != pat_all[BYTE_W*k[3:0] +: BYTE_W])) begin
        ok = 1'b0;
      end
    end
    seen_nxt = (seen_r < MAX_SEEN) ? seen_r + SEEN_W'(1) : seen_r;
    // Zero length never matches; the pattern must fit inside the region.
    hit = ok && (len_eff != '0) && (LEN_W'(seen_nxt) >= len_eff);
    count_nxt = count_r;
    start_nxt = start_r;
    if (hit) begin
      if (count_r != '1) begin
        count_nxt = count_r + COUNT_W'(1);
      end
      start_nxt = s1_addr_r - ADDR_W'(len_eff - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      count_r <= '0;
      start_r <= '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_r[j] <= '0;
      end
    end else if (s1_go) begin
      if (s1_last_r) begin
        // Region done: start the next one from scratch
        seen_r  <= '0;
        count_r <= '0;
        start_r <= '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
          win_r[j] <= '0;
        end
      end else begin
        seen_r  <= seen_nxt;
        count_r <= count_nxt;
        start_r <= start_nxt;
        for (int j = 0; j < MAX_PATTERN; j++) begin
          win_r[j] <= win_nxt[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_data_r <= {start_nxt, count_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // A region end clears the search state and loads a result.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> out_valid_r && seen_r == '0 && count_r == '0 && start_r == '0)
    else $error("region end did not clear state or load result");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= MAX_SEEN)
    else $error("fill count beyond window depth");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_last_r |=> count_r >= $past(count_r))
    else $error("match count went down inside a region");

  a_no_count_before_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_last_r && (LEN_W'(seen_nxt) < len_eff) |=> count_r == $past(count_r))
    else $error("match counted before pattern fits the region");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== verif/wildcard_byte_pattern_search_core_test.sv =====
module wildcard_byte_pattern_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  // Window depth of the search, matches the block's default parameter
  localparam int unsigned WINDOW = 16;
  // Cycles to let a byte beat settle in the block before a register write;
  // the result path is two stages deep, so this covers any byte in flight.
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASES = 8;
  localparam int unsigned BEATS_PER_PHASE = 75;

  // One region report, in out_tdata order (count low, location high)
  typedef struct packed {
    logic [ADDR_W-1:0]  location;
    logic [COUNT_W-1:0] count;
  } match_report_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  // One line of the directed script: either a register write or a byte beat.
  // For byte beats with typed set, the report is taken from the row itself.
  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic [BYTE_W-1:0]     data;
    logic [ADDR_W-1:0]     addr;
    logic                  last;
    logic                  typed;
    match_report_t         report;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  // data_byte [7:0], byte_address [39:8]
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // match_count [31:0], match_location [63:32]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Idle / stall percentages for the current phase
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned mismatches = 0;

  match_report_t expected_reports[$];
  script_row_t   script[$];

  // Shadow of the block: registers and the search state
  logic [CFG_DATA_W-1:0] pat_lo_m;
  logic [CFG_DATA_W-1:0] pat_hi_m;
  logic [CARE_W-1:0]     care_m;
  logic [LEN_W-1:0]      len_m;
  logic [BYTE_W-1:0]     window_m [WINDOW];
  int unsigned           seen_m;
  logic [COUNT_W-1:0]    hits_m;
  logic [ADDR_W-1:0]     start_m;

  wildcard_byte_pattern_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Pattern byte k, byte 0 in the low bits of the low register
  function automatic logic [BYTE_W-1:0] pattern_at(int unsigned k);
    return (k < 8) ? pat_lo_m[8*k +: 8] : pat_hi_m[8*(k-8) +: 8];
  endfunction

  // Bytes of the pattern in use; lengths past the window clamp to it
  function automatic int unsigned span();
    return (len_m > WINDOW) ? WINDOW : int'(len_m);
  endfunction

  function automatic void clear_search();
    foreach (window_m[i]) window_m[i] = '0;
    seen_m  = 0;
    hits_m  = '0;
    start_m = '0;
  endfunction

  // Shift one byte into the shadow window, update the match tally and return
  // 1 with the region report when the byte closes the region.
  function automatic bit scan_byte(input logic [BYTE_W-1:0] data,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic last,
                                   output match_report_t rep);
    int unsigned n;
    bit hit;
    n = span();
    for (int i = WINDOW - 1; i > 0; i--) window_m[i] = window_m[i-1];
    window_m[0] = data;
    if (seen_m < WINDOW) seen_m++;
    // whole pattern must sit inside the region; length zero never hits
    if (n != 0 && seen_m >= n) begin
      hit = 1'b1;
      for (int unsigned k = 0; k < n; k++) begin
        if (care_m[k] && window_m[n-1-k] != pattern_at(k)) hit = 1'b0;
      end
      if (hit) begin
        if (hits_m != '1) hits_m++;
        // start address wraps modulo 2^32
        start_m = addr - (n - 1);
      end
    end
    rep.count    = hits_m;
    rep.location = start_m;
    if (last) clear_search();
    return last;
  endfunction

  // Drop valid, let every pending report come back, then let the last beat
  // retire inside the block.
  task automatic await_idle();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Entered and left on a falling edge
  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    await_idle();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_PAT_LO: pat_lo_m = value;
      CFG_PAT_HI: pat_hi_m = value;
      CFG_CARE:   care_m   = value[CARE_W-1:0];
      CFG_LEN:    len_m    = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Entered and left on a falling edge; valid is kept high into the next
  // beat unless an idle gap is drawn.
  task automatic send_beat(input logic [BYTE_W-1:0] data, input logic [ADDR_W-1:0] addr,
                           input logic last, input logic typed,
                           input match_report_t typed_rep);
    match_report_t rep;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tdata  <= {addr, data};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (scan_byte(data, addr, last, rep)) expected_reports.push_back(typed ? typed_rep : rep);
    @(negedge clk);
  endtask

  function automatic void add_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    script_row_t row;
    row = '0;
    row.kind    = ROW_WRITE;
    row.reg_sel = sel;
    row.value   = value;
    script.push_back(row);
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] data, input logic [ADDR_W-1:0] addr,
                                   input logic last, input logic typed,
                                   input logic [COUNT_W-1:0] count,
                                   input logic [ADDR_W-1:0] location);
    script_row_t row;
    row = '0;
    row.kind            = ROW_BYTE;
    row.data            = data;
    row.addr            = addr;
    row.last            = last;
    row.typed           = typed;
    row.report.count    = count;
    row.report.location = location;
    script.push_back(row);
  endfunction

  // Report checker: every accepted result beat is matched against the oldest
  // pending report.
  match_report_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result beat: match_count %0h match_location %0h",
               out_tdata[31:0], out_tdata[63:32]);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (out_tdata[31:0] !== want.count) begin
          $error("match_count: expected %0h, got %0h", want.count, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== want.location) begin
          $error("match_location: expected %0h, got %0h", want.location, out_tdata[63:32]);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned     region_len;
    int unsigned     sent;
    int unsigned     guard;
    int              plant_k;
    logic [ADDR_W-1:0] addr_run;
    logic [BYTE_W-1:0] byte_val;
    logic [LEN_W-1:0]  len_val;
    logic [CARE_W-1:0] care_val;

    // register defaults and a clean search, as after reset
    pat_lo_m = '0;
    pat_hi_m = '0;
    care_m   = CARE_RST;
    len_m    = LEN_RST;
    clear_search();

    // ---- directed script ----
    // defaults: one-byte pattern 00, all bytes cared
    add_byte(8'h00, 32'h0000_0000, 1'b1, 1'b1, 32'd1, 32'h0);          // hit at address zero
    add_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0, 32'h0);          // miss, top address
    // zero length via masked write (upper data bits ignored): never matches
    add_write(CFG_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
    add_byte(8'h00, 32'h0000_0005, 1'b1, 1'b1, 32'd0, 32'h0);
    // length 31 clamps to 16; all wildcards; start address wraps below zero
    add_write(CFG_LEN, 64'd31);
    add_write(CFG_CARE, 64'hFFFF_FFFF_FFFF_0000);
    add_write(CFG_PAT_LO, '1);
    add_write(CFG_PAT_HI, '1);
    for (int i = 0; i < 16; i++) begin
      add_byte((i % 2) ? 8'hFF : 8'h00, 32'hFFFF_FFFA + i, i == 15, i == 15,
               32'd1, 32'hFFFF_FFFA);
    end
    // two-byte pattern, byte 0 wildcard, byte 1 = AB
    add_write(CFG_LEN, 64'd2);
    add_write(CFG_CARE, 64'h0002);
    add_write(CFG_PAT_LO, 64'h0000_0000_0000_ABCD);
    add_byte(8'hAB, 32'd100, 1'b1, 1'b1, 32'd0, 32'h0);                // region shorter than pattern
    add_byte(8'h11, 32'd100, 1'b0, 1'b0, '0, '0);
    add_byte(8'hAB, 32'd101, 1'b0, 1'b0, '0, '0);
    add_byte(8'hAB, 32'd102, 1'b1, 1'b0, '0, '0);                      // overlapping hits
    add_byte(8'h5A, 32'd0, 1'b0, 1'b0, '0, '0);
    add_byte(8'hAB, 32'd1, 1'b1, 1'b1, 32'd1, 32'h0);                  // match starting at zero

    // synchronous reset: rst_n held low from time zero, then released
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_WRITE) begin
        write_reg(script[r].reg_sel, script[r].value);
      end else begin
        send_beat(script[r].data, script[r].addr, script[r].last, script[r].typed,
                  script[r].report);
      end
    end

    // ---- random phases ----
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      // length extremes first, then random
      case (phase)
        0: len_val = 5'd1;
        1: len_val = 5'd16;
        2: len_val = 5'd0;
        3: len_val = 5'($urandom_range(17, 31));
        default: len_val = 5'($urandom_range(1, 16));
      endcase
      case (phase)
        4: care_val = '1;
        5: care_val = '0;
        default: care_val = 16'($urandom);
      endcase
      write_reg(CFG_PAT_LO, {32'($urandom), 32'($urandom)});
      write_reg(CFG_PAT_HI, {32'($urandom), 32'($urandom)});
      write_reg(CFG_CARE, {32'($urandom), 16'($urandom), care_val});
      write_reg(CFG_LEN, {32'($urandom), 27'($urandom), len_val});

      // Whole regions only, so a phase never ends mid-region.
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        region_len = ($urandom_range(7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 12);
        case ($urandom_range(3))
          0: addr_run = 32'($urandom_range(20));
          1: addr_run = 32'hFFFF_FFFF - 32'($urandom_range(20));
          default: addr_run = 32'($urandom);
        endcase
        plant_k = -1;
        for (int unsigned b = 0; b < region_len; b++) begin
          // plant a full pattern copy now and then; wildcard slots get noise
          if (plant_k < 0 && span() != 0 && $urandom_range(3) == 0) plant_k = 0;
          if (plant_k >= 0) begin
            byte_val = care_m[plant_k] ? pattern_at(plant_k) : 8'($urandom);
            plant_k  = (plant_k + 1 < int'(span())) ? plant_k + 1 : -1;
          end else if ($urandom_range(1) == 1) begin
            byte_val = pattern_at($urandom_range(WINDOW - 1));
          end else begin
            byte_val = 8'($urandom);
          end
          // occasional address jump: a broken run
          if ($urandom_range(19) == 0) addr_run = 32'($urandom);
          send_beat(byte_val, addr_run, b == region_len - 1, 1'b0, '0);
          addr_run++;
          sent++;
        end
      end
    end

    // ---- drain ----
    in_tvalid <= 1'b0;
    guard = 0;
    while (expected_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
